// ----- hdl/des_key_schedule_defines.svh -----
// ----------------------------------------------------------------------------
// DES key schedule assertion macros
// Shared assertion forms for the port checker of the key schedule.
// ----------------------------------------------------------------------------
`ifndef DES_KEY_SCHEDULE_DEFINES_SVH
`define DES_KEY_SCHEDULE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DKS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DKS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/dks_pkg.sv -----
// ----------------------------------------------------------------------------
// DES key schedule package
// Permutation tables, shift schedule and the bit-select functions.
// ----------------------------------------------------------------------------
`default_nettype none

package dks_pkg;

    localparam int HALF_W = 28;
    localparam int CD_W   = 56;
    localparam int SK_W   = 48;

    localparam logic [3:0] LAST_ROUND  = 4'd15;
    localparam logic [3:0] FIRST_ROUND = 4'd0;

    // Bit k is set when round k rotates both halves by two bits.
    localparam logic [15:0] SHIFT_TWO = 16'h7EFC;

    localparam logic [6:0] PC1_TAB [CD_W] = '{
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,  7'd58, 7'd50, 7'd42, 7'd34,
        7'd26, 7'd18, 7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
        7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,
        7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
        7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
    };

    localparam logic [6:0] PC2_TAB [SK_W] = '{
        7'd14, 7'd17, 7'd11, 7'd24, 7'd1,  7'd5,  7'd3,  7'd28, 7'd15, 7'd6,  7'd21, 7'd10,
        7'd23, 7'd19, 7'd12, 7'd4,  7'd26, 7'd8,  7'd16, 7'd7,  7'd27, 7'd20, 7'd13, 7'd2,
        7'd41, 7'd52, 7'd31, 7'd37, 7'd47, 7'd55, 7'd30, 7'd40, 7'd51, 7'd45, 7'd33, 7'd48,
        7'd44, 7'd49, 7'd39, 7'd56, 7'd34, 7'd53, 7'd46, 7'd42, 7'd50, 7'd36, 7'd29, 7'd32
    };

    typedef struct packed {
        logic                vld;
        logic [3:0]          rnd;
        logic [HALF_W-1:0]   c;
        logic [HALF_W-1:0]   d;
    } t_cd_word;

    function automatic logic [CD_W-1:0] pc1(input logic [63:0] key);
        logic [CD_W-1:0] r;
        r = '0;
        for (int i = 0; i < CD_W; i++) begin
            r[CD_W-1-i] = key[64-int'(PC1_TAB[i])];
        end
        return r;
    endfunction

    function automatic logic [SK_W-1:0] pc2(input logic [HALF_W-1:0] c,
                                            input logic [HALF_W-1:0] d);
        logic [CD_W-1:0] cd;
        logic [SK_W-1:0] r;
        cd = {c, d};
        r  = '0;
        for (int i = 0; i < SK_W; i++) begin
            r[SK_W-1-i] = cd[CD_W-int'(PC2_TAB[i])];
        end
        return r;
    endfunction

    function automatic logic [HALF_W-1:0] rot28(input logic [HALF_W-1:0] x, input logic two);
        logic [HALF_W-1:0] r;
        if (two) begin
            r = {x[HALF_W-3:0], x[HALF_W-1:HALF_W-2]};
        end else begin
            r = {x[HALF_W-2:0], x[HALF_W-1]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/des_key_schedule.sv -----
// ----------------------------------------------------------------------------
// DES key schedule
// Expands one 64-bit DES key into its sixteen 48-bit round subkeys.
//
// A key word enters on i_key when i_key_valid is high and o_key_stall is low.
// Each key yields sixteen subkey words in round order on o_subkey, each with
// its round number and a last flag on round fifteen, taken when o_sk_valid is
// high and i_sk_stall is low.
// The path has three register stages: the initial key permutation that drops
// the parity bits, the round stage that rotates the halves, and the output
// register after the subkey compression permutation. The first subkey of a
// key passes the input register, the round stage and the output register.
// The round stage emits one subkey per cycle while the output is not
// stalled. The next key waits in the input stage and
// enters the round stage in the cycle the last subkey of the previous key
// leaves it, so subkeys of back-to-back keys stream with no gap.
// Synchronous reset empties all stages. When the receiver stalls, the output
// word holds, the round stage holds, and the input side stalls once its
// stage is occupied; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module des_key_schedule (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_key_valid,
    input  wire logic [63:0]               i_key,
    output logic                           o_key_stall,
    output logic                           o_sk_valid,
    output logic [3:0]                     o_round_index,
    output logic [dks_pkg::SK_W-1:0]       o_subkey,
    output logic                           o_last,
    input  wire logic                      i_sk_stall
);

    logic                      a_vld;
    logic [dks_pkg::CD_W-1:0]  a_cd;
    logic                      b_take;
    logic                      c_rdy;
    dks_pkg::t_cd_word         b_word;

    dks_pc1 u_pc1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_key_valid),
        .i_key   (i_key),
        .i_take  (b_take),
        .o_stall (o_key_stall),
        .o_vld   (a_vld),
        .o_cd    (a_cd)
    );

    dks_rounds u_rounds (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (a_vld),
        .i_cd    (a_cd),
        .i_rdy   (c_rdy),
        .o_take  (b_take),
        .o_word  (b_word)
    );

    dks_pc2 u_pc2 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_word   (b_word),
        .i_stall  (i_sk_stall),
        .o_rdy    (c_rdy),
        .o_vld    (o_sk_valid),
        .o_rnd    (o_round_index),
        .o_subkey (o_subkey),
        .o_last   (o_last)
    );

endmodule

`default_nettype wire

// ----- hdl/dks_pc1.sv -----
// ----------------------------------------------------------------------------
// DES key schedule input stage
// Registers the key after the initial key permutation and holds it until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dks_pc1 (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_vld,
    input  wire logic [63:0]               i_key,
    input  wire logic                      i_take,
    output logic                           o_stall,
    output logic                           o_vld,
    output logic [dks_pkg::CD_W-1:0]       o_cd
);

    logic                      r_vld;
    logic                      n_vld;
    logic [dks_pkg::CD_W-1:0]  r_cd;
    logic                      accept;

    assign o_stall = r_vld && !i_take;
    assign accept  = i_vld && !o_stall;
    assign n_vld   = accept || (r_vld && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cd <= dks_pkg::pc1(i_key);
        end
    end

    assign o_vld = r_vld;
    assign o_cd  = r_cd;

endmodule

`default_nettype wire

// ----- hdl/dks_rounds.sv -----
// ----------------------------------------------------------------------------
// DES key schedule round stage
// Rotates the C and D halves once per round and steps the round counter.
// ----------------------------------------------------------------------------
`default_nettype none

module dks_rounds (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_vld,
    input  wire logic [dks_pkg::CD_W-1:0]  i_cd,
    input  wire logic                      i_rdy,
    output logic                           o_take,
    output dks_pkg::t_cd_word              o_word
);

    logic                        r_vld;
    logic                        n_vld;
    logic [3:0]                  r_rnd;
    logic [3:0]                  n_rnd;
    logic [dks_pkg::HALF_W-1:0]  r_c;
    logic [dks_pkg::HALF_W-1:0]  n_c;
    logic [dks_pkg::HALF_W-1:0]  r_d;
    logic [dks_pkg::HALF_W-1:0]  n_d;
    logic [3:0]                  rnd_inc;
    logic                        move;
    logic                        free;

    assign move    = r_vld && i_rdy;
    assign free    = !r_vld || (move && (r_rnd == dks_pkg::LAST_ROUND));
    assign rnd_inc = r_rnd + 4'd1;
    assign o_take  = free;

    always_comb begin
        n_vld = r_vld;
        n_rnd = r_rnd;
        n_c   = r_c;
        n_d   = r_d;
        if (free) begin
            n_vld = i_vld;
            if (i_vld) begin
                n_rnd = dks_pkg::FIRST_ROUND;
                n_c   = dks_pkg::rot28(i_cd[dks_pkg::CD_W-1:dks_pkg::HALF_W],
                                       dks_pkg::SHIFT_TWO[dks_pkg::FIRST_ROUND]);
                n_d   = dks_pkg::rot28(i_cd[dks_pkg::HALF_W-1:0],
                                       dks_pkg::SHIFT_TWO[dks_pkg::FIRST_ROUND]);
            end
        end else if (move) begin
            n_rnd = rnd_inc;
            n_c   = dks_pkg::rot28(r_c, dks_pkg::SHIFT_TWO[rnd_inc]);
            n_d   = dks_pkg::rot28(r_d, dks_pkg::SHIFT_TWO[rnd_inc]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_rnd <= dks_pkg::FIRST_ROUND;
        end else begin
            r_vld <= n_vld;
            r_rnd <= n_rnd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c <= n_c;
        r_d <= n_d;
    end

    assign o_word.vld = r_vld;
    assign o_word.rnd = r_rnd;
    assign o_word.c   = r_c;
    assign o_word.d   = r_d;

endmodule

`default_nettype wire

// ----- hdl/dks_pc2.sv -----
// ----------------------------------------------------------------------------
// DES key schedule output stage
// Forms the subkey by the compression permutation into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dks_pc2 (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire dks_pkg::t_cd_word         i_word,
    input  wire logic                      i_stall,
    output logic                           o_rdy,
    output logic                           o_vld,
    output logic [3:0]                     o_rnd,
    output logic [dks_pkg::SK_W-1:0]       o_subkey,
    output logic                           o_last
);

    logic                      r_vld;
    logic [3:0]                r_rnd;
    logic [dks_pkg::SK_W-1:0]  r_subkey;
    logic                      r_last;
    logic                      load;

    assign o_rdy = !r_vld || !i_stall;
    assign load  = o_rdy && i_word.vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_word.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rnd    <= i_word.rnd;
            r_subkey <= dks_pkg::pc2(i_word.c, i_word.d);
            r_last   <= (i_word.rnd == dks_pkg::LAST_ROUND);
        end
    end

    assign o_vld    = r_vld;
    assign o_rnd    = r_rnd;
    assign o_subkey = r_subkey;
    assign o_last   = r_last;

endmodule

`default_nettype wire

// ----- hdl/dks_checker.sv -----
// ----------------------------------------------------------------------------
// DES key schedule port checker
// Watches the top-level ports for output hold and round sequencing.
// ----------------------------------------------------------------------------
`default_nettype none
`include "des_key_schedule_defines.svh"

module dks_checker (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      o_sk_valid,
    input  wire logic [3:0]                o_round_index,
    input  wire logic [dks_pkg::SK_W-1:0]  o_subkey,
    input  wire logic                      o_last,
    input  wire logic                      i_sk_stall
);

    logic sk_acc;

    assign sk_acc = o_sk_valid && !i_sk_stall;

    `DKS_ASSERT_NXT(a_sk_hold, o_sk_valid && i_sk_stall, o_sk_valid && $stable(o_subkey) && $stable(o_round_index) && $stable(o_last), "stalled subkey word changed")

    `DKS_ASSERT_IMP(a_last_flag, o_sk_valid, o_last == (o_round_index == dks_pkg::LAST_ROUND), "last flag does not match round fifteen")

    `DKS_ASSERT_NXT(a_round_next, sk_acc && !o_last, o_sk_valid && (o_round_index == $past(o_round_index) + 4'd1), "subkey rounds not contiguous")

    `DKS_ASSERT_NXT(a_first_round, sk_acc && o_last, !o_sk_valid || (o_round_index == dks_pkg::FIRST_ROUND), "key did not restart at round zero")

endmodule

bind des_key_schedule dks_checker u_dks_checker (.*);

`default_nettype wire
